>>> rtl/aprs_path_alias_digipeat_assert.svh
// Assertion macros for the APRS path-alias digipeat block.
`ifndef APRS_PATH_ALIAS_DIGIPEAT_ASSERT_SVH
`define APRS_PATH_ALIAS_DIGIPEAT_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every rising edge of clk, switched off while arst_n is low.
`define APD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Checked on every rising edge of clk, also during reset.
`define APD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define APD_ASSERT(label, prop, msg)
`define APD_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

>>> rtl/apd_pkg.sv
// Package: constants, types and shifted-ASCII codes for the path-alias digipeater.
`default_nettype none

package apd_pkg;

	// Highest hop count n accepted in WIDEn / SPn / DLn.
	localparam int unsigned MAX_HOPS = 3;

	localparam int unsigned ADDR_W = 56;
	localparam int unsigned APB_DW = 64;
	localparam int unsigned APB_AW = 4;

	// Register indexes (byte address 8*i, decoded on paddr[3]).
	localparam logic REG_DIGI_ENABLE = 1'b0;
	localparam logic REG_OWN_ADDRESS = 1'b1;

	// AX.25 address characters, ASCII shifted left by one.
	localparam logic [7:0] SH_W  = {7'h57, 1'b0};
	localparam logic [7:0] SH_I  = {7'h49, 1'b0};
	localparam logic [7:0] SH_D  = {7'h44, 1'b0};
	localparam logic [7:0] SH_E  = {7'h45, 1'b0};
	localparam logic [7:0] SH_1  = {7'h31, 1'b0};
	localparam logic [7:0] SH_SP = {7'h20, 1'b0};
	localparam logic [7:0] SH_R  = {7'h52, 1'b0};
	localparam logic [7:0] SH_L  = {7'h4C, 1'b0};
	localparam logic [7:0] SH_A  = {7'h41, 1'b0};
	localparam logic [7:0] SH_Y  = {7'h59, 1'b0};
	localparam logic [7:0] SH_S  = {7'h53, 1'b0};
	localparam logic [7:0] SH_P  = {7'h50, 1'b0};

	// SSID byte with reserved bits set and count zero.
	localparam logic [7:0] SSID_BASE = 8'h60;
	// SSID byte of WIDE1-1.
	localparam logic [7:0] SSID_WIDE11 = 8'h62;

	// RELAY in bytes 0..4 (byte 0 lowest).
	localparam logic [39:0] RELAY_PAT = {SH_Y, SH_A, SH_L, SH_E, SH_R};
	// WIDE1-1 as a full 7-byte address.
	localparam logic [ADDR_W-1:0] WIDE11_ADDR =
		{SSID_WIDE11, SH_SP, SH_1, SH_E, SH_D, SH_I, SH_W};

	// Legal range of the unshifted hop digit.
	localparam logic [6:0] HOP_LO = 7'h31;
	localparam logic [6:0] HOP_HI = 7'(7'h30 + MAX_HOPS);

	typedef enum logic [2:0] {
		RSN_FORWARDED = 3'd0,
		RSN_DISABLED  = 3'd1,
		RSN_REPEATED  = 3'd2,
		RSN_NO_ALIAS  = 3'd3,
		RSN_NO_N      = 3'd4,
		RSN_N_RANGE   = 3'd5,
		RSN_SSID_ZERO = 3'd6,
		RSN_DUPLICATE = 3'd7
	} reason_t;

	// Decision flags handed from the decision logic to the result register.
	typedef struct packed {
		logic    forward;
		logic    no_mark;
		reason_t reason;
	} decision_t;

endpackage

`default_nettype wire

>>> rtl/apd_decide.sv
// Combinational alias recognition, checks and address rewrite for one address.
`default_nettype none

module apd_decide
	import apd_pkg::*;
(
	input  wire logic              digi_enable,
	input  wire logic [ADDR_W-1:0] own_address,
	input  wire logic [ADDR_W-1:0] address,
	input  wire logic              seen_recently,
	output      decision_t         decision,
	output      logic [ADDR_W-1:0] address_new
);

	logic              is_relay;
	logic [ADDR_W-1:0] addr_r;
	logic              is_wide;
	logic              is_spdl;
	logic [7:0]        n_byte;
	logic [6:0]        hop;
	logic              hop_ok;
	logic [3:0]        cnt;
	logic [3:0]        cnt_dec;

	// RELAY is turned into WIDE1-1 before alias matching
	assign is_relay = (address[39:0] == RELAY_PAT);
	assign addr_r   = is_relay ? WIDE11_ADDR : address;

	// WIDEn: bytes 0..3 WIDE, byte 5 space, n in byte 4
	assign is_wide = (addr_r[7:0] == SH_W) && (addr_r[15:8] == SH_I) &&
		(addr_r[23:16] == SH_D) && (addr_r[31:24] == SH_E) &&
		(addr_r[47:40] == SH_SP);

	// SPn / DLn: byte 3 space, n in byte 2
	assign is_spdl = (addr_r[31:24] == SH_SP) &&
		(((addr_r[7:0] == SH_S) && (addr_r[15:8] == SH_P)) ||
		 ((addr_r[7:0] == SH_D) && (addr_r[15:8] == SH_L)));

	assign n_byte  = is_wide ? addr_r[39:32] : addr_r[23:16];
	assign hop     = n_byte[7:1];
	assign hop_ok  = (hop >= HOP_LO) && (hop <= HOP_HI);
	assign cnt     = addr_r[52:49];
	assign cnt_dec = cnt - 4'd1;

	// Checks in priority order; first failure sets the reason
	always_comb begin
		decision.forward = 1'b0;
		decision.no_mark = 1'b0;
		decision.reason  = RSN_FORWARDED;
		address_new      = address;
		if (!digi_enable) begin
			decision.reason = RSN_DISABLED;
		end else if (address[55]) begin
			decision.reason = RSN_REPEATED;
		end else begin
			address_new = addr_r;
			if (!is_wide && !is_spdl) begin
				decision.reason = RSN_NO_ALIAS;
			end else if (n_byte == SH_SP) begin
				decision.reason = RSN_NO_N;
			end else if (!hop_ok) begin
				decision.reason = RSN_N_RANGE;
			end else if (cnt == 4'd0) begin
				decision.reason = RSN_SSID_ZERO;
			end else if (seen_recently) begin
				decision.reason = RSN_DUPLICATE;
			end else begin
				decision.forward = 1'b1;
				if (cnt == 4'd1) begin
					// last hop: own call for n=1, else used-up SSID
					if (hop == HOP_LO) begin
						address_new = own_address;
					end else begin
						address_new[55:48] = SSID_BASE;
					end
				end else begin
					address_new[55:48] = SSID_BASE | {3'b000, cnt_dec, 1'b0};
					decision.no_mark   = 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/aprs_path_alias_digipeat.sv
// Top level: APB registers, input register, decision logic and result register.
`default_nettype none
`include "aprs_path_alias_digipeat_assert.svh"

// APRS path-alias digipeater (WIDEn-N, SPn-N, DLn-N, RELAY).
// One address is taken per clock cycle: busy is always low, so start may be
// held high on consecutive cycles. Each transaction gives one result (input
// register, decision logic, result register), marked by a one-cycle done
// strobe; the receiver cannot stall and must capture the result in that
// cycle. Registers at byte address 0 (digi_enable, bit 0) and 8 (own_address,
// bits 55:0) are to be written over APB only while no transaction is in
// flight, which the block does not enforce; paddr bit 3 selects the register.

module aprs_path_alias_digipeat
	import apd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// command channel
	input  wire logic              start,
	output      logic              busy,
	input  wire logic [ADDR_W-1:0] address_in,
	input  wire logic              seen_recently,
	// result channel
	output      logic              done,
	output      logic              forward,
	output      logic              no_mark,
	output      logic [ADDR_W-1:0] address_out,
	output      logic [2:0]        reason,
	// configuration
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output      logic [APB_DW-1:0] prdata,
	output      logic              pready
);

	logic              digi_enable_q;
	logic [ADDR_W-1:0] own_address_q;
	logic              cfg_wr;

	logic              valid_s1;
	logic [ADDR_W-1:0] address_s1;
	logic              seen_s1;

	decision_t         decision;
	logic [ADDR_W-1:0] address_new;

	logic              valid_s2;
	decision_t         decision_s2;
	logic [ADDR_W-1:0] address_s2;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digi_enable_q <= 1'b0;
			own_address_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[3] == REG_DIGI_ENABLE) begin
				digi_enable_q <= pwdata[0];
			end else begin
				own_address_q <= pwdata[ADDR_W-1:0];
			end
		end
	end

	// Read back
	always_comb begin
		if (paddr[3] == REG_OWN_ADDRESS) begin
			prdata = {{(APB_DW-ADDR_W){1'b0}}, own_address_q};
		end else begin
			prdata = {{(APB_DW-1){1'b0}}, digi_enable_q};
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			address_s1 <= address_in;
			seen_s1    <= seen_recently;
		end
	end

	// Decision logic
	apd_decide u_decide (
		.digi_enable   (digi_enable_q),
		.own_address   (own_address_q),
		.address       (address_s1),
		.seen_recently (seen_s1),
		.decision      (decision),
		.address_new   (address_new)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			decision_s2 <= decision;
			address_s2  <= address_new;
		end
	end

	assign done        = valid_s2;
	assign forward     = decision_s2.forward;
	assign no_mark     = decision_s2.no_mark;
	assign address_out = address_s2;
	assign reason      = decision_s2.reason;

	// Checks
	`APD_ASSERT(a_result_follows, valid_s1 |=> done, "accepted transaction gave no result")
	`APD_ASSERT(a_nomark_fwd, (done && no_mark) |-> forward, "no_mark set on a rejected address")
	`APD_ASSERT(a_fwd_reason, done |-> (forward == (reason == RSN_FORWARDED)), "forward and reason disagree")
	`APD_ASSERT(a_disabled, (done && digi_enable_q) |-> (reason != RSN_DISABLED), "disabled reason while enabled")
	`APD_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")

endmodule

`default_nettype wire
